[hdl/skt_pkg.sv]
// Shared types and constants of the smallest-k tracker.
package skt_pkg;

	localparam int VALUE_W = 32;
	localparam int KEEP_W  = 5;

	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd4;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [KEEP_W-1:0] keep_t;

	typedef struct packed {
		logic insert;
		logic shift;
		logic flush;
	} cell_ctrl_t;

endpackage

[hdl/skt_channels.sv]
// Channel interfaces of the smallest-k tracker: samples, results and configuration.
interface skt_sample_if;
	logic           valid;
	logic           ready;
	skt_pkg::value_t sample;
	logic           end_of_set;

	modport source (output valid, output sample, output end_of_set, input ready);
	modport sink (input valid, input sample, input end_of_set, output ready);
endinterface

interface skt_result_if;
	logic            valid;
	logic            ready;
	skt_pkg::value_t smallest_value;
	logic            final_result;
	logic            too_few_items;

	modport source (output valid, output smallest_value, output final_result,
		output too_few_items, input ready);
	modport sink (input valid, input smallest_value, input final_result,
		input too_few_items, output ready);
endinterface

interface skt_cfg_if;
	logic           valid;
	logic           ready;
	skt_pkg::keep_t keep_count;

	modport source (output valid, output keep_count, input ready);
	modport sink (input valid, input keep_count, output ready);
endinterface

[hdl/skt_cell.sv]
// One compare-and-shift cell of the sorted chain.
module skt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  skt_pkg::cell_ctrl_t ctrl,
	input  logic                active,
	input  skt_pkg::value_t     sample,
	input  skt_pkg::value_t     left_value,
	input  logic                left_less,
	input  logic                left_valid,
	input  skt_pkg::value_t     right_value,
	output skt_pkg::value_t     value,
	output logic                less,
	output logic                valid,
	output logic                valid_next
);

	skt_pkg::value_t value_q;
	logic            valid_q;

	assign value      = value_q;
	assign valid      = valid_q;
	assign less       = active & (~valid_q | (sample < value_q));
	assign valid_next = active & (valid_q | left_valid);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right_value;
		end else if (ctrl.insert && less) begin
			value_q <= left_less ? left_value : sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.flush) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			valid_q <= valid_next;
		end
	end

endmodule

[hdl/smallest_k_tracker.sv]
// Top level of the smallest-k tracker: cell chain, drain control and configuration register.
// Keeps the k smallest signed samples of a set in a chain of MAX_KEEP compare-and-shift
// cells, ascending from cell 0; k is keep_count held between 1 and MAX_KEEP. While a set
// streams in, one sample request is taken every cycle and inserted in a single step. The
// request marked end_of_set is inserted too; then the chain drains through cell 0 into the
// result channel, one result per accepted result request: k results with the last marked,
// or a single result flagged too_few_items when the set held fewer than k samples. The
// sample channel is held off for the whole drain. Reset clears the valid bits of the cells
// at once; no clearing pass is needed. The user must write keep_count only while the block
// is idle; the block itself does not enforce this.
module smallest_k_tracker #(
	parameter int MAX_KEEP = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	skt_sample_if.sink   samples,
	skt_result_if.source results,
	skt_cfg_if.sink      cfg
);

	localparam int CW = $clog2(MAX_KEEP + 1);
	localparam int EW = (CW > skt_pkg::KEEP_W) ? CW : skt_pkg::KEEP_W;
	localparam logic [EW-1:0] MAX_E = EW'(MAX_KEEP);

	skt_pkg::keep_t      keep_count_q;
	logic                draining_q;
	logic                too_few_q;
	logic [CW-1:0]       rem_q;

	logic [EW-1:0]       k_ext;
	logic [EW-1:0]       k_sat;
	logic [CW-1:0]       k_eff;
	logic                in_fire;
	logic                out_fire;
	logic                last_result;
	logic                full;
	skt_pkg::cell_ctrl_t ctrl;

	skt_pkg::value_t     values [MAX_KEEP];
	logic [MAX_KEEP-1:0] less;
	logic [MAX_KEEP-1:0] valid;
	logic [MAX_KEEP-1:0] valid_next;
	logic [MAX_KEEP-1:0] active;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= skt_pkg::KEEP_RESET;
		end else if (cfg.valid) begin
			keep_count_q <= cfg.keep_count;
		end
	end

	// saturate k into 1 .. MAX_KEEP
	always_comb begin
		k_ext = EW'(keep_count_q);
		k_sat = k_ext;
		if (k_ext == '0) begin
			k_sat = EW'(1);
		end else if (k_ext > MAX_E) begin
			k_sat = MAX_E;
		end
		k_eff = k_sat[CW-1:0];
	end

	assign in_fire     = samples.valid & samples.ready;
	assign out_fire    = results.valid & results.ready;
	assign last_result = (rem_q == CW'(1));

	assign ctrl.insert = in_fire;
	assign ctrl.shift  = out_fire & ~too_few_q;
	assign ctrl.flush  = out_fire & last_result;

	assign full = &(valid_next | ~active);

	genvar i;
	generate
		for (i = 0; i < MAX_KEEP; i++) begin : g_cell
			skt_pkg::value_t left_value;
			skt_pkg::value_t right_value;
			logic            left_less;
			logic            left_valid;

			assign active[i] = (k_eff > CW'(i));

			if (i == 0) begin : g_head
				assign left_value = samples.sample;
				assign left_less  = 1'b0;
				assign left_valid = 1'b1;
			end else begin : g_body
				assign left_value = values[i-1];
				assign left_less  = less[i-1];
				assign left_valid = valid[i-1];
			end

			if (i == MAX_KEEP - 1) begin : g_tail
				assign right_value = values[i];
			end else begin : g_inner
				assign right_value = values[i+1];
			end

			skt_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.active      (active[i]),
				.sample      (samples.sample),
				.left_value  (left_value),
				.left_less   (left_less),
				.left_valid  (left_valid),
				.right_value (right_value),
				.value       (values[i]),
				.less        (less[i]),
				.valid       (valid[i]),
				.valid_next  (valid_next[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			too_few_q  <= 1'b0;
			rem_q      <= '0;
		end else if (in_fire && samples.end_of_set) begin
			draining_q <= 1'b1;
			too_few_q  <= ~full;
			rem_q      <= full ? k_eff : CW'(1);
		end else if (out_fire) begin
			if (last_result) begin
				draining_q <= 1'b0;
			end
			rem_q <= rem_q - CW'(1);
		end
	end

	assign samples.ready          = ~draining_q;
	assign results.valid          = draining_q;
	assign results.smallest_value = too_few_q ? '0 : values[0];
	assign results.final_result   = last_result;
	assign results.too_few_items  = too_few_q;

endmodule
